### rtl/ove_pkg.sv
// ----------------------------------------------------------------------------
// ove_pkg
// shared types, codes and constants of the oscillator envelope voice
// ----------------------------------------------------------------------------
package ove_pkg;

  localparam int LEN_W = 24;
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  // item kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_ON   = 2'd1;
  localparam logic [1:0] KIND_OFF  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_WAVE    = 3'd0;
  localparam logic [2:0] REG_STEP    = 3'd1;
  localparam logic [2:0] REG_FM      = 3'd2;
  localparam logic [2:0] REG_ATTACK  = 3'd3;
  localparam logic [2:0] REG_DECAY   = 3'd4;
  localparam logic [2:0] REG_SUSTAIN = 3'd5;
  localparam logic [2:0] REG_RELEASE = 3'd6;

  // waveform codes
  localparam logic [1:0] WAVE_SAW      = 2'd0;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
  localparam logic [1:0] WAVE_SQUARE   = 2'd2;
  localparam logic [1:0] WAVE_SINE     = 2'd3;

  localparam logic [3:0] HORNER_TOP = 4'd4;
  localparam logic [3:0] DIV_TOP    = 4'd14;

  typedef struct packed {
    logic [1:0]       wave_select;
    logic [31:0]      phase_step;
    logic [15:0]      fm_depth;
    logic [LEN_W-1:0] attack_len;
    logic [LEN_W-1:0] decay_len;
    logic [15:0]      sustain_level;
    logic [LEN_W-1:0] release_len;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_NOTE_ON, OP_NOTE_OFF, OP_FM, OP_PHASE, OP_SQR,
    OP_HORNER, OP_SIN1, OP_SIN2, OP_WAVE, OP_ATT_LD, OP_DEC_LD, OP_REL_LD,
    OP_DIV_STEP, OP_ATT_TAKE, OP_DEC_TAKE, OP_REL_TAKE, OP_ENV1, OP_ENV2,
    OP_MIX, OP_FINISH
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FM, ST_PHASE, ST_SQR, ST_HORNER, ST_SIN1, ST_SIN2, ST_WAVE,
    ST_ATT_LD, ST_ATT_DIV, ST_ATT_TAKE, ST_DEC_LD, ST_DEC_DIV, ST_DEC_TAKE,
    ST_REL_LD, ST_REL_DIV, ST_REL_TAKE, ST_ENV1, ST_ENV2, ST_MIX, ST_FINISH
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // sine polynomial, signed q6.28
  function automatic logic signed [33:0] poly_coef(logic [2:0] i);
    logic signed [33:0] c;
    unique case (i)
      3'd0:    c = -34'sd843314854;
      3'd1:    c = 34'sd543882302;
      3'd2:    c = -34'sd140669883;
      3'd3:    c = 34'sd20182927;
      3'd4:    c = -34'sd1841518;
      default: c = 34'sd103599;
    endcase
    return c;
  endfunction

endpackage

### rtl/ove_if.sv
// ----------------------------------------------------------------------------
// ove_if
// item channels of the voice: event input and sample output
// ----------------------------------------------------------------------------
interface ove_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] fm_value;
  modport source(output valid, kind, fm_value, input ready);
  modport sink(input valid, kind, fm_value, output ready);
endinterface

interface ove_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          voice_active;
  modport source(output valid, sample_out, voice_active, input ready);
  modport sink(input valid, sample_out, voice_active, output ready);
endinterface

### rtl/ove_ctrl.sv
// ----------------------------------------------------------------------------
// ove_ctrl
// sequencer that steps the datapath through one sample tick
// ----------------------------------------------------------------------------
module ove_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    kind,
  output logic          in_ready,
  input  ove_pkg::stat_t stat,
  output ove_pkg::cmd_t  cmd
);
  import ove_pkg::*;

  state_t     state, state_next;
  logic [3:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && kind == KIND_TICK) state_next = ST_FM;
      end
      ST_FM:    state_next = ST_PHASE;
      ST_PHASE: state_next = ST_SQR;
      ST_SQR: begin
        state_next = ST_HORNER;
        cnt_next   = HORNER_TOP;
      end
      ST_HORNER: begin
        if (cnt == '0) state_next = ST_SIN1;
        else cnt_next = cnt - 4'd1;
      end
      ST_SIN1: state_next = ST_SIN2;
      ST_SIN2: state_next = ST_WAVE;
      ST_WAVE: state_next = ST_ATT_LD;
      ST_ATT_LD: begin
        state_next = ST_ATT_DIV;
        cnt_next   = DIV_TOP;
      end
      ST_ATT_DIV: begin
        if (cnt == '0) state_next = ST_ATT_TAKE;
        else cnt_next = cnt - 4'd1;
      end
      ST_ATT_TAKE: state_next = ST_DEC_LD;
      ST_DEC_LD: begin
        state_next = ST_DEC_DIV;
        cnt_next   = DIV_TOP;
      end
      ST_DEC_DIV: begin
        if (cnt == '0) state_next = ST_DEC_TAKE;
        else cnt_next = cnt - 4'd1;
      end
      ST_DEC_TAKE: state_next = ST_REL_LD;
      ST_REL_LD: begin
        state_next = ST_REL_DIV;
        cnt_next   = DIV_TOP;
      end
      ST_REL_DIV: begin
        if (cnt == '0) state_next = ST_REL_TAKE;
        else cnt_next = cnt - 4'd1;
      end
      ST_REL_TAKE: state_next = ST_ENV1;
      ST_ENV1:     state_next = ST_ENV2;
      ST_ENV2:     state_next = ST_MIX;
      ST_MIX:      state_next = ST_FINISH;
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    cmd.idx  = cnt[2:0];
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          priority case (kind)
            KIND_TICK: cmd.op = OP_ACCEPT;
            KIND_ON:   cmd.op = OP_NOTE_ON;
            KIND_OFF:  cmd.op = OP_NOTE_OFF;
            default:   cmd.op = OP_NONE;
          endcase
        end
      end
      ST_FM:       cmd.op = OP_FM;
      ST_PHASE:    cmd.op = OP_PHASE;
      ST_SQR:      cmd.op = OP_SQR;
      ST_HORNER:   cmd.op = OP_HORNER;
      ST_SIN1:     cmd.op = OP_SIN1;
      ST_SIN2:     cmd.op = OP_SIN2;
      ST_WAVE:     cmd.op = OP_WAVE;
      ST_ATT_LD:   cmd.op = OP_ATT_LD;
      ST_DEC_LD:   cmd.op = OP_DEC_LD;
      ST_REL_LD:   cmd.op = OP_REL_LD;
      ST_ATT_DIV,
      ST_DEC_DIV,
      ST_REL_DIV:  cmd.op = OP_DIV_STEP;
      ST_ATT_TAKE: cmd.op = OP_ATT_TAKE;
      ST_DEC_TAKE: cmd.op = OP_DEC_TAKE;
      ST_REL_TAKE: cmd.op = OP_REL_TAKE;
      ST_ENV1:     cmd.op = OP_ENV1;
      ST_ENV2:     cmd.op = OP_ENV2;
      ST_MIX:      cmd.op = OP_MIX;
      ST_FINISH:   cmd.op = stat.out_free ? OP_FINISH : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

### rtl/ove_datapath.sv
// ----------------------------------------------------------------------------
// ove_datapath
// phase accumulator, wave shaper, shared divider, envelope and output register
// ----------------------------------------------------------------------------
module ove_datapath #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ove_pkg::cfg_t                 cfg,
  input  ove_pkg::cmd_t                 cmd,
  output ove_pkg::stat_t                stat,
  input  logic signed [15:0]            fm_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          voice_active
);
  import ove_pkg::*;

  localparam int CW = (TIME_BITS > LEN_W) ? TIME_BITS : LEN_W;
  localparam int NW = CW + 16;

  // voice state
  logic [31:0]          phase_acc;
  logic [TIME_BITS-1:0] press_count, release_count;
  logic                 released_flag;

  // working registers
  logic signed [15:0] fm_r;
  logic [7:0]         fmm;
  logic [16:0]        x2;
  logic signed [33:0] acc;
  logic signed [15:0] wav;
  logic [15:0]        att, dec, rel, adsr, env;
  logic signed [15:0] smp;
  logic [NW-1:0]      rem, dsh;
  logic [14:0]        quo;

  // combinational helpers
  logic signed [32:0] fm_prod;
  logic [40:0]        phase_inc;
  logic signed [15:0] x16, tri_saw, tri_val, sine_val;
  logic signed [31:0] xsq;
  logic signed [51:0] hmul;
  logic signed [17:0] x2s, x2m1;
  logic signed [20:0] sine_pre;
  logic [CW-1:0]      tc, rc, a_len, d_len, r_len, t_minus_a;
  logic [15:0]        sus, one_m_s;
  logic [31:0]        eprod;
  logic signed [32:0] mprod;
  logic signed [17:0] mix;
  logic [CW:0]        rc_inc;

  assign x16     = {~phase_acc[31], phase_acc[30:16]};
  assign tri_saw = {~phase_acc[30], phase_acc[29:15]};
  assign x2s     = $signed({1'b0, x2});
  assign x2m1    = x2s - 18'sd32768;
  assign tc      = CW'(press_count);
  assign rc      = CW'(release_count);
  assign a_len   = CW'(cfg.attack_len);
  assign d_len   = CW'(cfg.decay_len);
  assign r_len   = CW'(cfg.release_len);
  assign t_minus_a = tc - a_len;
  assign sus     = (cfg.sustain_level > ONE_Q15) ? ONE_Q15 : cfg.sustain_level;
  assign one_m_s = ONE_Q15 - sus;
  assign rc_inc  = {1'b0, rc} + (CW+1)'(1);

  always_comb begin
    fm_prod   = fm_r * $signed({1'b0, cfg.fm_depth});
    phase_inc = 41'(cfg.phase_step) * 41'({1'b0, fmm} + 9'd1);
    xsq       = x16 * x16;
    unique case (cmd.op)
      OP_SIN1: hmul = acc * x2m1;
      OP_SIN2: hmul = acc * x16;
      default: hmul = acc * x2s;
    endcase
    // triangle with saturating negation
    if (phase_acc[31]) begin
      tri_val = (tri_saw == -16'sd32768) ? 16'sd32767 : -tri_saw;
    end else begin
      tri_val = tri_saw;
    end
    sine_pre = acc[33:13];
    if (sine_pre > 21'sd32767) sine_val = 16'sd32767;
    else if (sine_pre < -21'sd32768) sine_val = -16'sd32768;
    else sine_val = sine_pre[15:0];
    unique case (cmd.op)
      OP_ENV2: eprod = adsr * rel;
      default: eprod = att * dec;
    endcase
    mprod = wav * $signed({1'b0, env});
    mix   = mprod[32:15];
  end

  assign stat.out_free = !out_valid || out_ready;

  // voice state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc     <= '0;
      press_count   <= '0;
      release_count <= '0;
      released_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_NOTE_ON: begin
          press_count   <= '0;
          released_flag <= 1'b0;
        end
        OP_NOTE_OFF: begin
          release_count <= '0;
          released_flag <= 1'b1;
        end
        OP_PHASE: phase_acc <= phase_acc + phase_inc[31:0];
        OP_FINISH: begin
          if (press_count != '1) press_count <= press_count + TIME_BITS'(1);
          if (release_count != '1) release_count <= release_count + TIME_BITS'(1);
        end
        default: ;
      endcase
      if (cmd.op == OP_FINISH) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // sample rescale
  logic signed [SAMPLE_BITS-1:0] scaled;
  generate
    if (SAMPLE_BITS >= 16) begin : g_up
      assign scaled = SAMPLE_BITS'(smp) <<< (SAMPLE_BITS - 16);
    end else begin : g_dn
      assign scaled = smp[15 -: SAMPLE_BITS];
    end
  endgenerate

  // arithmetic registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: fm_r <= fm_value;
      OP_FM:     fmm <= (fm_prod > 33'sd0) ? fm_prod[30:23] : 8'd0;
      OP_SQR: begin
        x2  <= xsq[31:15];
        acc <= poly_coef(3'd5);
      end
      OP_HORNER: acc <= hmul[48:15] + poly_coef(cmd.idx);
      OP_SIN1, OP_SIN2: acc <= hmul[48:15];
      OP_WAVE: begin
        unique case (cfg.wave_select)
          WAVE_SAW:      wav <= x16;
          WAVE_TRIANGLE: wav <= tri_val;
          WAVE_SQUARE:   wav <= phase_acc[31] ? 16'sd32767 : -16'sd32768;
          WAVE_SINE:     wav <= sine_val;
          default:       wav <= x16;
        endcase
      end
      OP_ATT_LD: begin
        rem <= NW'(tc) << 15;
        dsh <= NW'(a_len) << 14;
      end
      OP_DEC_LD: begin
        rem <= NW'(one_m_s) * NW'(t_minus_a);
        dsh <= NW'(d_len) << 14;
      end
      OP_REL_LD: begin
        rem <= NW'(rc) << 15;
        dsh <= NW'(r_len) << 14;
      end
      OP_DIV_STEP: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[13:0], 1'b1};
        end else begin
          quo <= {quo[13:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
      OP_ATT_TAKE: att <= (tc >= a_len) ? ONE_Q15 : {1'b0, quo};
      OP_DEC_TAKE: begin
        if (tc <= a_len) dec <= ONE_Q15;
        else if (t_minus_a >= d_len) dec <= sus;
        else dec <= ONE_Q15 - {1'b0, quo};
      end
      OP_REL_TAKE: begin
        if (!released_flag) rel <= ONE_Q15;
        else if (rc >= r_len) rel <= '0;
        else rel <= ONE_Q15 - {1'b0, quo};
      end
      OP_ENV1: adsr <= eprod[30:15];
      OP_ENV2: env <= eprod[30:15];
      OP_MIX: begin
        if (mix > 18'sd32767) smp <= 16'sd32767;
        else if (mix < -18'sd32768) smp <= -16'sd32768;
        else smp <= mix[15:0];
      end
      OP_FINISH: begin
        sample_out   <= scaled;
        voice_active <= !released_flag || (rc_inc < {1'b0, r_len});
      end
      default: ;
    endcase
  end

endmodule

### rtl/oscillator_envelope_voice.sv
// ----------------------------------------------------------------------------
// oscillator_envelope_voice
// one synthesizer voice: phase oscillator shaped by an adsr and release envelope
// ----------------------------------------------------------------------------
// a sample tick runs from accept to result through phase and wave, then three
// envelope divisions on one shared 15-step divider, envelope products and mix,
// then a final stage that waits for the output register to free up; the voice
// takes no new tick until that final stage is done
// note on and note off leave the sequencer idle and give no result
// rst is synchronous: config returns to its defaults, voice state is cleared
module oscillator_envelope_voice #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 24
) (
  input  logic          clk,
  input  logic          rst,
  ove_in_if.sink        req,
  ove_out_if.source     rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import ove_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  cfg_wr;

  // apb register file, one word per register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_select   <= 2'd0;
      cfg.phase_step    <= 32'd0;
      cfg.fm_depth      <= 16'd0;
      cfg.attack_len    <= LEN_W'(24000);
      cfg.decay_len     <= LEN_W'(9600);
      cfg.sustain_level <= 16'd19661;
      cfg.release_len   <= LEN_W'(24000);
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_WAVE:    cfg.wave_select   <= pwdata[1:0];
        REG_STEP:    cfg.phase_step    <= pwdata;
        REG_FM:      cfg.fm_depth      <= pwdata[15:0];
        REG_ATTACK:  cfg.attack_len    <= pwdata[LEN_W-1:0];
        REG_DECAY:   cfg.decay_len     <= pwdata[LEN_W-1:0];
        REG_SUSTAIN: cfg.sustain_level <= pwdata[15:0];
        REG_RELEASE: cfg.release_len   <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[4:2])
      REG_WAVE:    prdata = {30'd0, cfg.wave_select};
      REG_STEP:    prdata = cfg.phase_step;
      REG_FM:      prdata = {16'd0, cfg.fm_depth};
      REG_ATTACK:  prdata = 32'(cfg.attack_len);
      REG_DECAY:   prdata = 32'(cfg.decay_len);
      REG_SUSTAIN: prdata = {16'd0, cfg.sustain_level};
      REG_RELEASE: prdata = 32'(cfg.release_len);
      default:     prdata = 32'd0;
    endcase
  end

  // sequencer
  ove_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .kind     (req.kind),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and voice state; result register feeds the output channel
  ove_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .fm_value     (req.fm_value),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .sample_out   (rsp.sample_out),
    .voice_active (rsp.voice_active)
  );

`ifndef SYNTHESIS
  // a tick keeps the voice busy for the following cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.kind == KIND_TICK |=> !req.ready)
    else $error("input taken right after a tick");

  // note events and unknown kinds leave the voice ready
  a_event_fast: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.kind != KIND_TICK |=> req.ready)
    else $error("voice stalled after a note event");
`endif

endmodule

### tb/tb_ove_scoreboard.sv
// ----------------------------------------------------------------------------
// tb_ove_scoreboard
// voice predictor and expected sample store for the oscillator envelope voice
// ----------------------------------------------------------------------------
import ove_pkg::*;

class voice_scoreboard;
  logic [1:0]  wave;
  logic [31:0] step;
  logic [15:0] depth;
  logic [23:0] att_len, dec_len, rel_len;
  logic [15:0] sus_lvl;
  logic [31:0] phase;
  longint      press_cnt, rel_cnt;
  bit          released;
  logic [15:0] exp_sample[$];
  bit          exp_active[$];
  int          errors;

  function new();
    errors = 0;
    reset_state();
  endfunction

  function void reset_state();
    wave = WAVE_SAW; step = 0; depth = 0;
    att_len = 24000; dec_len = 9600; sus_lvl = 19661; rel_len = 24000;
    phase = 0; press_cnt = 0; rel_cnt = 0; released = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_WAVE:    wave = v[1:0];
      REG_STEP:    step = v;
      REG_FM:      depth = v[15:0];
      REG_ATTACK:  att_len = v[23:0];
      REG_DECAY:   dec_len = v[23:0];
      REG_SUSTAIN: sus_lvl = v[15:0];
      REG_RELEASE: rel_len = v[23:0];
      default: ;
    endcase
  endfunction

  static function longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  static function longint sat16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  static function longint saw(logic [31:0] p);
    return longint'(p[31:16]) - 32768;
  endfunction

  function longint shape(logic [31:0] p);
    longint s, x, x2, acc;
    case (wave)
      WAVE_SAW: return saw(p);
      WAVE_TRIANGLE: begin
        s = saw(p << 1);
        if (p[31]) s = (s == -32768) ? 32767 : -s;
        return s;
      end
      WAVE_SQUARE: return p[31] ? 32767 : -32768;
      default: begin
        x = saw(p);
        x2 = (x * x) >>> 15;
        acc = 103599;
        acc = fshr(acc * x2, 15) - 1841518;
        acc = fshr(acc * x2, 15) + 20182927;
        acc = fshr(acc * x2, 15) - 140669883;
        acc = fshr(acc * x2, 15) + 543882302;
        acc = fshr(acc * x2, 15) - 843314854;
        acc = fshr(acc * (x2 - 32768), 15);
        acc = fshr(acc * x, 15);
        return sat16(fshr(acc, 13));
      end
    endcase
  endfunction

  function longint adsr_gain(longint t);
    longint a, d, s, att, dcy;
    a = att_len; d = dec_len;
    s = sus_lvl > 32768 ? 32768 : sus_lvl;
    att = (t >= a) ? 32768 : (t * 32768) / a;
    if (t <= a) dcy = 32768;
    else if (t - a >= d) dcy = s;
    else dcy = 32768 - ((32768 - s) * (t - a)) / d;
    return (att * dcy) >>> 15;
  endfunction

  function longint release_gain(longint r);
    if (!released) return 32768;
    if (r >= rel_len) return 0;
    return 32768 - (r * 32768) / rel_len;
  endfunction

  // note an accepted input item
  function void note_event(logic [1:0] kind, logic signed [15:0] fm);
    longint prod, mult, env, smp;
    if (kind == KIND_ON) begin
      press_cnt = 0; released = 0;
    end else if (kind == KIND_OFF) begin
      rel_cnt = 0; released = 1;
    end else if (kind == KIND_TICK) begin
      prod = longint'(fm) * longint'(depth);
      mult = prod > 0 ? prod >> 23 : 0;
      phase = phase + 32'(longint'(step) * (1 + mult));
      env = (adsr_gain(press_cnt) * release_gain(rel_cnt)) >>> 15;
      smp = sat16(fshr(shape(phase) * env, 15));
      exp_sample.push_back(smp[15:0]);
      exp_active.push_back(!released || (rel_cnt + 1 < rel_len));
      if (press_cnt < 24'hFFFFFF) press_cnt++;
      if (rel_cnt < 24'hFFFFFF) rel_cnt++;
    end
  endfunction

  // check one result against the oldest expectation
  function void check_sample(logic [15:0] smp, logic act);
    logic [15:0] es;
    bit ea;
    if (exp_sample.size() == 0) begin
      $error("unexpected sample %0h", smp);
      errors++;
      return;
    end
    es = exp_sample.pop_front();
    ea = exp_active.pop_front();
    if (smp !== es) begin
      $error("sample_out expected %0d actual %0d", $signed(es), $signed(smp));
      errors++;
    end
    if (act !== ea) begin
      $error("voice_active expected %0d actual %0d", ea, act);
      errors++;
    end
  endfunction

  function int pending();
    return exp_sample.size();
  endfunction
endclass

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives note events and ticks into one voice, checks every sample against a
// local predictor, and sweeps the register settings between phases
// ----------------------------------------------------------------------------
module testbench;
  import ove_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  longint      cycle_cnt;
  bit          in_held;

  ove_in_if  req_if ();
  ove_out_if #(.SAMPLE_BITS(16)) rsp_if ();

  oscillator_envelope_voice u_top (
    .clk(clk), .rst(rst), .req(req_if.sink), .rsp(rsp_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  voice_scoreboard voice_sb = new();

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // global watchdog: ends the run with an error once the cycle count passes its limit
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > 600000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: random stall per item, check at the accepting edge
  initial begin
    rsp_if.ready = 0;
    @(negedge clk);
    forever begin
      int stall;
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        rsp_if.ready <= 0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
      voice_sb.check_sample(rsp_if.sample_out, rsp_if.voice_active);
      @(negedge clk);
    end
  end

  // register write, only while the voice is idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    voice_sb.write_reg(idx, v);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // drop valid after the last item of a burst
  task automatic release_in();
    if (in_held) begin
      req_if.valid <= 0;
      in_held = 0;
    end
  endtask

  task automatic send_item(logic [1:0] kind, logic signed [15:0] fm, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      release_in();
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1; req_if.kind <= kind; req_if.fm_value <= fm;
    do @(posedge clk); while (!req_if.ready);
    voice_sb.note_event(kind, fm);
    @(negedge clk);
    in_held = 1;
  endtask

  // wait for all samples, then a short settle so note events finish too
  task automatic drain();
    release_in();
    while (voice_sb.pending() != 0) @(posedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic load_config(logic [1:0] w, logic [31:0] st, logic [15:0] fd,
                             logic [23:0] a, logic [23:0] d, logic [15:0] s,
                             logic [23:0] r);
    drain();
    write_reg(REG_WAVE, w);
    write_reg(REG_STEP, st);
    write_reg(REG_FM, fd);
    write_reg(REG_ATTACK, a);
    write_reg(REG_DECAY, d);
    write_reg(REG_SUSTAIN, s);
    write_reg(REG_RELEASE, r);
  endtask

  // random phrase: note on, then ticks with a note off at the middle and stray note on, note off or unknown items
  task automatic phrase(int n_ticks);
    bit burst;
    burst = $urandom_range(0, 3) == 0;
    send_item(KIND_ON, 16'($urandom), burst);
    for (int i = 0; i < n_ticks; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(2'($urandom_range(1, 3)), 16'($urandom), burst);
      else if (i == n_ticks / 2)
        send_item(KIND_OFF, 16'($urandom), burst);
      else
        send_item(KIND_TICK, 16'($urandom), burst);
    end
  endtask

  initial begin
    logic [1:0] w;
    int ticks;
    rst = 1;
    in_held = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    req_if.valid = 0; req_if.kind = KIND_TICK; req_if.fm_value = 0;
    repeat (7) @(negedge clk);
    rst = 0;

    // directed: defaults first, extremes of fm and every kind
    send_item(KIND_TICK, 16'sh7FFF, 0);
    send_item(KIND_ON, 0, 0);
    send_item(KIND_TICK, -16'sd32768, 0);
    send_item(2'd3, 16'sh1234, 0);
    send_item(KIND_OFF, 0, 0);
    send_item(KIND_TICK, 0, 0);

    // zero lengths and sustain above one, big fm, each waveform
    for (int k = 0; k < 4; k++) begin
      load_config(2'(k), 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 16'hFFFF, 0);
      send_item(KIND_ON, 0, 0);
      send_item(KIND_TICK, 16'sh7FFF, 0);
      send_item(KIND_TICK, -16'sd32768, 0);
      send_item(KIND_OFF, 0, 0);
      send_item(KIND_TICK, 16'sh4000, 0);
    end

    // short lengths, counters reach and pass every stage
    load_config(WAVE_SINE, 32'h0800_0000, 16'h0100, 3, 2, 0, 2);
    send_item(KIND_ON, 0, 0);
    for (int i = 0; i < 8; i++) send_item(KIND_TICK, 16'($urandom), 0);
    send_item(KIND_OFF, 0, 0);
    for (int i = 0; i < 4; i++) send_item(KIND_TICK, 16'($urandom), 0);

    // random phases: new settings, then phrases
    for (int ph = 0; ph < 12; ph++) begin
      w = 2'($urandom);
      load_config(w, $urandom, 16'($urandom),
                  24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)),
                  24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)),
                  16'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 32768)),
                  24'($urandom_range(0, 3) == 0 ? 24'hFFFFFF : $urandom_range(0, 40)));
      for (int p = 0; p < 3; p++) begin
        ticks = $urandom_range(10, 40);
        phrase(ticks);
      end
      // sender holds off until every sample has arrived
      if (ph == 5) begin
        release_in();
        while (voice_sb.pending() != 0) @(negedge clk);
      end
    end

    release_in();
    while (voice_sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (voice_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### oscillator_envelope_voice.f
rtl/ove_pkg.sv
rtl/ove_if.sv
rtl/ove_ctrl.sv
rtl/ove_datapath.sv
rtl/oscillator_envelope_voice.sv
tb/tb_ove_scoreboard.sv
tb/testbench.sv
